// ===== sv/sli_pkg.sv =====
// Package with the shared types and codes of the sorted list core.
`default_nettype none

package sli_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Operation kinds.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } kind_t;

  // Read address selection for the entry memory.
  typedef enum logic [2:0] {
    RD_IDX_M1 = 3'd0,
    RD_IDX    = 3'd1,
    RD_IDX_P1 = 3'd2,
    RD_FIRST  = 3'd3,
    RD_LAST   = 3'd4
  } rd_sel_t;

  // Write data selection for the entry memory.
  typedef enum logic {
    WR_RDATA = 1'b0,
    WR_VALUE = 1'b1
  } wr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    idx_inc;
    logic    idx_dec;
    logic    occ_inc;
    logic    occ_dec;
    logic    set_status;
    status_t status_code;
    logic    cap_small;
    logic    cap_large;
    logic    clear_ends;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic occ_zero;
    logic idx_zero;
    logic idx_at_occ;
    logic next_at_occ;
    logic rd_below;
    logic rd_equal;
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/sorted_list_insert_remove_core.sv =====
// Top level of the sorted list core: a bounded ascending table of signed values.
//
// Usage: present kind and value with start high while busy is low; the
// transaction is accepted at that clock edge and busy rises in the next cycle.
// kind 0 inserts value after all smaller entries, kind 1 removes one entry
// equal to value. Each transaction gives one result, shown for exactly one
// cycle with done high: status, count, empty_res, smallest and largest.
// The receiver cannot stall; the result must be taken in the cycle done is high.
// start is taken again in the cycle after done. The entry memory moves one entry
// at a time (registered read and compare, then write).
// After reset the table is empty and the core is idle; no clearing pass runs.
`default_nettype none

module sorted_list_insert_remove_core import sli_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               kind,
  input  wire logic signed [31:0] value,
  output logic                    busy,
  output logic                    done,
  output logic             [1:0]  status,
  output logic             [4:0]  count,
  output logic                    empty_res,
  output logic signed      [31:0] smallest,
  output logic signed      [31:0] largest
);

  cmd_t  cmd;
  stat_t stat;

  // Operation sequencer.
  sli_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Table storage and result registers.
  sli_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .kind      (kind),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .status    (status),
    .count     (count),
    .empty_res (empty_res),
    .smallest  (smallest),
    .largest   (largest)
  );

endmodule

`default_nettype wire

// ===== sv/sli_dpath.sv =====
// Datapath of the sorted list core: entry memory, index, occupancy and results.
`default_nettype none

module sli_dpath import sli_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               kind,
  input  wire logic signed [31:0] value,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  output logic             [1:0]  status,
  output logic             [4:0]  count,
  output logic                    empty_res,
  output logic signed      [31:0] smallest,
  output logic signed      [31:0] largest
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic        [31:0]   mem [CAPACITY];
  logic        [31:0]   rdata;
  logic signed [31:0]   value_q;
  logic        [CW-1:0] idx;
  logic        [CW-1:0] occ;
  logic        [CW-1:0] raddr;
  logic        [31:0]   wdata;
  logic        [1:0]    status_q;

  // Read address selection.
  always_comb begin
    case (cmd.rd_sel)
      RD_IDX_M1: raddr = idx - CW'(1);
      RD_IDX:    raddr = idx;
      RD_IDX_P1: raddr = idx + CW'(1);
      RD_FIRST:  raddr = '0;
      RD_LAST:   raddr = occ - CW'(1);
      default:   raddr = idx;
    endcase
  end

  assign wdata = (cmd.wr_sel == WR_VALUE) ? value_q : rdata;

  // Entry memory: one write at the index and one registered read at raddr per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx[AW-1:0]] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr[AW-1:0]];
    end
  end

  // Operand capture and walk index.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_q <= value;
      idx     <= (kind == OP_REMOVE) ? '0 : occ;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx - CW'(1);
    end
  end

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.occ_inc) begin
      occ <= occ + CW'(1);
    end else if (cmd.occ_dec) begin
      occ <= occ - CW'(1);
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.set_status) begin
      status_q <= cmd.status_code;
    end
    if (cmd.clear_ends) begin
      smallest <= '0;
      largest  <= '0;
    end else begin
      if (cmd.cap_small) begin
        smallest <= rdata;
      end
      if (cmd.cap_large) begin
        largest <= rdata;
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.full        = (occ == CW'(CAPACITY));
    stat.occ_zero    = (occ == '0);
    stat.idx_zero    = (idx == '0);
    stat.idx_at_occ  = (idx == occ);
    stat.next_at_occ = ((idx + CW'(1)) == occ);
    stat.rd_below    = ($signed(rdata) < value_q);
    stat.rd_equal    = (rdata == value_q);
  end

  assign status    = status_q;
  assign count     = 5'(occ);
  assign empty_res = (occ == '0);

endmodule

`default_nettype wire

// ===== sv/sli_ctrl.sv =====
// Controller of the sorted list core: sequences the memory walks of each operation.
`default_nettype none

module sli_ctrl import sli_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire logic  kind,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_INS_RD  = 11'b00000000010,
    S_INS_CMP = 11'b00000000100,
    S_REM_RD  = 11'b00000001000,
    S_REM_CMP = 11'b00000010000,
    S_SHF_RD  = 11'b00000100000,
    S_SHF_WR  = 11'b00001000000,
    S_SUM0    = 11'b00010000000,
    S_SUM1    = 11'b00100000000,
    S_SUM2    = 11'b01000000000,
    S_FIRE    = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.rd_sel      = RD_IDX;
    cmd.wr_sel      = WR_RDATA;
    cmd.status_code = ST_INSERTED;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (kind == OP_REMOVE) begin
            state_next = S_REM_RD;
          end else if (stat.full) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_FULL;
            state_next      = S_SUM0;
          end else begin
            state_next = S_INS_RD;
          end
        end
      end
      // Walk down from the tail, moving every entry not below the value up one slot.
      S_INS_RD: begin
        if (stat.idx_zero) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_sel     = WR_VALUE;
          cmd.occ_inc    = 1'b1;
          cmd.set_status = 1'b1;
          state_next     = S_SUM0;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (!stat.rd_below) begin
          cmd.idx_dec = 1'b1;
          state_next  = S_INS_RD;
        end else begin
          cmd.wr_sel     = WR_VALUE;
          cmd.occ_inc    = 1'b1;
          cmd.set_status = 1'b1;
          state_next     = S_SUM0;
        end
      end
      // Walk up from the head to the first entry not below the value.
      S_REM_RD: begin
        if (stat.idx_at_occ) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOT_FOUND;
          state_next      = S_SUM0;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        if (stat.rd_below) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_REM_RD;
        end else if (stat.rd_equal) begin
          state_next = S_SHF_RD;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOT_FOUND;
          state_next      = S_SUM0;
        end
      end
      // Close the gap by moving the later entries down one slot.
      S_SHF_RD: begin
        if (stat.next_at_occ) begin
          cmd.occ_dec     = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_REMOVED;
          state_next      = S_SUM0;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_P1;
          state_next = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = S_SHF_RD;
      end
      // Fetch the first and last entries for the result, or clear both when the table is empty.
      S_SUM0: begin
        if (stat.occ_zero) begin
          cmd.clear_ends = 1'b1;
          state_next     = S_FIRE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_FIRST;
          state_next = S_SUM1;
        end
      end
      S_SUM1: begin
        cmd.cap_small = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_LAST;
        state_next    = S_SUM2;
      end
      S_SUM2: begin
        cmd.cap_large = 1'b1;
        state_next    = S_FIRE;
      end
      S_FIRE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FIRE);

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking sorted list core testbench: directed cases and random insert/remove bursts.
module tb;
  import sli_pkg::*;

  localparam int TABLE_DEPTH = 16;

  // One pending operation for the driver; hold_for_drain keeps it back until
  // every earlier transaction has produced its result.
  typedef struct {
    kind_t              op;
    logic signed [31:0] operand;
    bit                 hold_for_drain;
  } table_op_t;

  // Result that the table should report after one operation.
  typedef struct {
    status_t            st;
    logic        [4:0]  cnt;
    logic               emp;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } table_view_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               kind = 1'b0;
  logic signed [31:0] value = '0;
  logic               busy;
  logic               done;
  logic        [1:0]  status;
  logic        [4:0]  count;
  logic               empty_res;
  logic signed [31:0] smallest;
  logic signed [31:0] largest;

  table_op_t          op_q[$];
  table_view_t        predicted_q[$];
  logic signed [31:0] held[$];
  int                 accepted_n = 0;
  int                 results_seen = 0;
  int                 mismatches = 0;
  int                 burst_left = 0;
  int                 gap_left = 0;
  int                 status_seen[4] = '{0, 0, 0, 0};
  int                 peak_count = 0;
  int                 drain_pauses = 0;

  sorted_list_insert_remove_core #(.CAPACITY(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .value     (value),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .count     (count),
    .empty_res (empty_res),
    .smallest  (smallest),
    .largest   (largest)
  );

  // Clock with a period of 10 time units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one operation to the shadow table and returns what the core should show.
  function automatic table_view_t table_apply(kind_t op, logic signed [31:0] v);
    table_view_t r;
    int          pos = 0;
    while (pos < held.size() && held[pos] < v) pos++;
    if (op == OP_INSERT) begin
      if (held.size() >= TABLE_DEPTH) begin
        r.st = ST_FULL;
      end else begin
        held.insert(pos, v);
        r.st = ST_INSERTED;
      end
    end else if (pos < held.size() && held[pos] == v) begin
      held.delete(pos);
      r.st = ST_REMOVED;
    end else begin
      r.st = ST_NOT_FOUND;
    end
    r.cnt = 5'(held.size());
    r.emp = (held.size() == 0);
    r.lo  = r.emp ? 32'sd0 : held[0];
    r.hi  = r.emp ? 32'sd0 : held[held.size() - 1];
    return r;
  endfunction

  // Draws an operand: fully random, near zero, or one of min, max, -1 and 0.
  function automatic logic signed [31:0] draw_operand();
    case ($urandom_range(2))
      0: return $urandom;
      1: return 32'(int'($urandom_range(40)) - 20);
      default: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
    endcase
  endfunction

  task automatic queue_op(kind_t op, logic signed [31:0] v, bit hold);
    table_op_t item;
    item.op             = op;
    item.operand        = v;
    item.hold_for_drain = hold;
    op_q.push_back(item);
  endtask

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Driver: offers the head of the queue in bursts and predicts each accepted transaction.
  always @(posedge clk) begin
    bit took;
    bit offer;
    took  = 1'b0;
    offer = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        took = 1'b1;
        predicted_q.push_back(table_apply(op_q[0].op, op_q[0].operand));
        op_q.pop_front();
        accepted_n <= accepted_n + 1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else if (gap_left > 0) begin
        gap_left--;
      end
      if (op_q.size() > 0 && gap_left == 0) begin
        offer = !(op_q[0].hold_for_drain && (accepted_n + took) != results_seen);
      end
      start <= offer;
      if (offer) begin
        kind  <= op_q[0].op;
        value <= op_q[0].operand;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    table_view_t want;
    if (!rst && done) begin
      if (results_seen >= accepted_n) begin
        report("result strobe with no transaction outstanding");
      end else begin
        want = predicted_q.pop_front();
        results_seen <= results_seen + 1;
        if (status !== want.st)
          report($sformatf("status %0d, expected %0d", status, want.st));
        if (count !== want.cnt)
          report($sformatf("count %0d, expected %0d", count, want.cnt));
        if (empty_res !== want.emp)
          report($sformatf("empty_res %0b, expected %0b", empty_res, want.emp));
        if (smallest !== want.lo)
          report($sformatf("smallest %0d, expected %0d", smallest, want.lo));
        if (largest !== want.hi)
          report($sformatf("largest %0d, expected %0d", largest, want.hi));
        status_seen[want.st]++;
        if (want.cnt > peak_count) peak_count = want.cnt;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic signed [31:0] pool[6];
    logic signed [31:0] v;
    int                 ep_len;
    int                 ins_pct;
    int                 pick;
    int                 pct_choice[4];

    pct_choice = '{25, 50, 65, 85};

    // Directed: remove from an empty table, fill to capacity with the extremes
    // and a duplicate, overflow, then remove an absent value whose neighbor is
    // larger, a duplicate, the tail, the head and a middle entry.
    queue_op(OP_REMOVE, 32'sd0, 1'b0);
    queue_op(OP_INSERT, 32'sh8000_0000, 1'b0);
    queue_op(OP_INSERT, 32'sh7fff_ffff, 1'b0);
    queue_op(OP_INSERT, 32'sd0, 1'b0);
    queue_op(OP_INSERT, -32'sd1, 1'b0);
    queue_op(OP_INSERT, 32'sd1, 1'b0);
    queue_op(OP_INSERT, 32'sd5, 1'b0);
    queue_op(OP_INSERT, 32'sd5, 1'b0);
    for (int i = 9; i >= 1; i--) queue_op(OP_INSERT, 32'(i * 10), 1'b0);
    queue_op(OP_INSERT, 32'sd7, 1'b0);
    queue_op(OP_REMOVE, 32'sd3, 1'b0);
    queue_op(OP_REMOVE, 32'sd5, 1'b0);
    queue_op(OP_REMOVE, 32'sh7fff_ffff, 1'b0);
    queue_op(OP_REMOVE, 32'sh8000_0000, 1'b0);
    queue_op(OP_REMOVE, 32'sd0, 1'b0);

    // Random episodes: a small operand pool so removes often hit, and an
    // insert bias per episode so the table swings between empty and full.
    while (op_q.size() < 800) begin
      ep_len  = $urandom_range(20, 60);
      ins_pct = pct_choice[$urandom_range(3)];
      foreach (pool[i]) pool[i] = draw_operand();
      for (int n = 0; n < ep_len; n++) begin
        pick = $urandom_range(99);
        v = pool[$urandom_range(5)];
        if (pick < 5) v = v + 32'sd1;
        else if (pick < 10) v = $urandom;
        queue_op(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE, v,
                 n == 0 && $urandom_range(2) == 0);
      end
    end
    op_q[23].hold_for_drain = 1'b1;
    foreach (op_q[i]) if (op_q[i].hold_for_drain) drain_pauses++;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (op_q.size() > 0 || results_seen != accepted_n) @(negedge clk);
    repeat (2 * TABLE_DEPTH + 20) @(negedge clk);

    $display("Ran %0d transactions with %0d drain pauses; peak count %0d.",
             accepted_n, drain_pauses, peak_count);
    $display("Outcomes: %0d inserted, %0d removed, %0d not found, %0d dropped as full.",
             status_seen[ST_INSERTED], status_seen[ST_REMOVED],
             status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
    if (mismatches == 0) begin
      $display("sorted_list_insert_remove_core regression: pass");
    end else begin
      $display("sorted_list_insert_remove_core regression: fail");
    end
    $finish;
  end

  // Watchdog for a core that hangs or never drops busy.
  initial begin
    #5_000_000;
    $display("Timeout with %0d transactions still outstanding.", op_q.size());
    $display("sorted_list_insert_remove_core regression: fail");
    $finish;
  end

endmodule
